// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/wsdsc_pkg.sv =====
// types, constants and helper functions for the wheel speed dip shot counter
package wsdsc_pkg;

    // averaging window and history depth
    localparam int WINDOW     = 5;
    localparam int HIST_DEPTH = WINDOW + 1;

    // field and internal widths
    localparam int SAMPLE_W = 17;
    localparam int MAG_W    = 16;
    localparam int THR_W    = 16;
    localparam int COUNT_W  = 32;
    localparam int FILL_W   = $clog2(HIST_DEPTH + 1);
    localparam int LIM_W    = THR_W + $clog2(WINDOW + 1);
    localparam int CMP_W    = LIM_W + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = 1'd1;

    // reset values of the thresholds
    localparam logic [THR_W-1:0] DROP_THRESHOLD_RST = 16'd300;
    localparam logic [THR_W-1:0] RISE_THRESHOLD_RST = 16'd50;

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [LIM_W-1:0] lim_t;

    // one result item
    typedef struct packed {
        logic [COUNT_W-1:0] shots_counted;
        logic               shot_now;
        logic               armed;
        logic               history_full;
    } result_t;

    // magnitude of a signed sample, saturated to the magnitude width
    function automatic mag_t mag_sat(input logic signed [SAMPLE_W-1:0] x);
        logic [SAMPLE_W-1:0] abs_val;
        abs_val = x[SAMPLE_W-1] ? (SAMPLE_W'(0) - SAMPLE_W'(x)) : SAMPLE_W'(x);
        return abs_val[SAMPLE_W-1] ? {MAG_W{1'b1}} : abs_val[MAG_W-1:0];
    endfunction

    // threshold scaled by the window length
    function automatic lim_t scale_thr(input logic [THR_W-1:0] thr);
        return LIM_W'(thr) * LIM_W'(WINDOW);
    endfunction

endpackage

// ===== sv/wheel_speed_dip_shot_counter_top.sv =====
// top level of the wheel speed dip shot counter
// a result is registered into the output register, or into the skid register while the output is held
// throughput: one sample per cycle while in_stall is low; the combinational compare path sets the rate
// a two-entry result buffer (output plus skid register) keeps input stall registered
// reset: asynchronous active low; clears fill level, arm flag, shot count, buffer state
// reset also loads the thresholds 300 and 50; the history is not cleared
module wheel_speed_dip_shot_counter_top
    import wsdsc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [THR_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_W-1:0]  speed_sample,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [COUNT_W-1:0]          shots_counted,
    output logic                        shot_now,
    output logic                        armed,
    output logic                        history_full
);

`include "assert_macros.svh"

    // scaled thresholds
    lim_t drop_lim_reg;
    lim_t rise_lim_reg;

    // block state
    mag_t               hist_reg [HIST_DEPTH];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               armed_reg;
    logic               armed_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // result buffer
    logic    out_valid_reg;
    logic    skid_full_reg;
    result_t out_reg;
    result_t skid_reg;

    logic                     in_xfer;
    logic                     out_xfer;
    mag_t                     mag;
    logic                     full_new;
    logic signed [CMP_W-1:0]  diff;
    logic                     is_drop;
    logic                     is_rise;
    logic                     shot_new;
    result_t                  res_new;

    assign in_stall = skid_full_reg;
    assign in_xfer  = in_valid && !skid_full_reg;
    assign out_xfer = out_valid_reg && !out_stall;

    // configuration writes, thresholds stored already scaled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_lim_reg <= scale_thr(DROP_THRESHOLD_RST);
            rise_lim_reg <= scale_thr(RISE_THRESHOLD_RST);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_DROP_THRESHOLD: drop_lim_reg <= scale_thr(cfg_data);
                REG_RISE_THRESHOLD: rise_lim_reg <= scale_thr(cfg_data);
                default: ;
            endcase
        end
    end

    // newest minus oldest against the scaled thresholds
    always_comb
    begin
        mag        = mag_sat(speed_sample);
        full_new   = (fill_reg >= FILL_W'(HIST_DEPTH - 1));
        fill_next  = (fill_reg < FILL_W'(HIST_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
        diff       = $signed(CMP_W'(mag)) - $signed(CMP_W'(hist_reg[1]));
        is_drop    = diff < -$signed(CMP_W'(drop_lim_reg));
        is_rise    = diff > $signed(CMP_W'(rise_lim_reg));
        shot_new   = full_new && !is_drop && is_rise && armed_reg;
        armed_next = armed_reg;
        count_next = count_reg;
        if (full_new && is_drop)
        begin
            armed_next = 1'b1;
        end
        else if (shot_new)
        begin
            armed_next = 1'b0;
            count_next = count_reg + 1'b1;
        end
        res_new.shots_counted = count_next;
        res_new.shot_now      = shot_new;
        res_new.armed         = armed_next;
        res_new.history_full  = full_new;
    end

    // sample history shift line, oldest at index 0
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int i = 0; i < HIST_DEPTH - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[HIST_DEPTH-1] <= mag;
        end
    end

    // control state update on each sample transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            armed_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (in_xfer)
        begin
            fill_reg  <= fill_next;
            armed_reg <= armed_next;
            count_reg <= count_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_xfer)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_full_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_xfer)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_reg <= res_new;
            end
            else
            begin
                out_reg <= res_new;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign shots_counted = out_reg.shots_counted;
    assign shot_now      = out_reg.shot_now;
    assign armed         = out_reg.armed;
    assign history_full  = out_reg.history_full;

    // checks
    `ASSERT_IMPLY(a_skid_needs_out, clk, rst_n, skid_full_reg, out_valid_reg)
    `ASSERT_IMPLY(a_shot_disarms, clk, rst_n, in_xfer && shot_new, full_new && !armed_next)
    `ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_W'(HIST_DEPTH))
    `ASSERT_NEXT(a_count_step, clk, rst_n, in_xfer, count_reg == $past(count_reg) + COUNT_W'($past(shot_new)))

endmodule

// ===== bench/dip_shot_monitor.sv =====
// watches the wheel speed dip shot counter channels, predicts each result and compares
`timescale 1ns / 100ps

module dip_shot_monitor
    import wsdsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  speed_sample,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [COUNT_W-1:0]   shots_counted,
    input  logic                 shot_now,
    input  logic                 armed,
    input  logic                 history_full,
    output int                   mismatches,
    output int                   pending
);

    // own copy of the thresholds and the shot detection state
    logic [THR_W-1:0]   drop_thr;
    logic [THR_W-1:0]   rise_thr;
    logic [MAG_W-1:0]   speed_hist [HIST_DEPTH];
    int                 fill_count;
    logic               dip_armed;
    logic [COUNT_W-1:0] shot_tally;

    // results still owed by the block, oldest first
    result_t shot_results_due [$];

    // advance the detector by one sample and give the result it must produce
    task automatic count_dip_shot(input logic [SAMPLE_W-1:0] raw, output result_t res);
        int   level;
        int   span;
        int   i;
        int   mag_max;
        logic full;
        mag_max = (1 << MAG_W) - 1;
        level = int'($signed(raw));
        if (level < 0)
        begin
            level = -level;
        end
        // -65536 has no 16-bit magnitude, clamp it
        if (level > mag_max)
        begin
            level = mag_max;
        end
        for (i = 0; i < HIST_DEPTH - 1; i++)
        begin
            speed_hist[i] = speed_hist[i + 1];
        end
        speed_hist[HIST_DEPTH - 1] = MAG_W'(level);
        if (fill_count < HIST_DEPTH)
        begin
            fill_count++;
        end
        full = (fill_count == HIST_DEPTH);
        res.shot_now = 1'b0;
        // newest minus oldest is window times the change of the boxcar average
        if (full)
        begin
            span = int'(speed_hist[HIST_DEPTH - 1]) - int'(speed_hist[0]);
            if (span < -(int'(drop_thr) * WINDOW))
            begin
                dip_armed = 1'b1;
            end
            else if (span > int'(rise_thr) * WINDOW && dip_armed)
            begin
                shot_tally = shot_tally + 1'b1;
                dip_armed = 1'b0;
                res.shot_now = 1'b1;
            end
        end
        res.shots_counted = shot_tally;
        res.armed = dip_armed;
        res.history_full = full;
    endtask

    // follow register writes, sample transfers and result transfers
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t due;
        if (!rst_n)
        begin
            drop_thr = DROP_THRESHOLD_RST;
            rise_thr = RISE_THRESHOLD_RST;
            fill_count = 0;
            dip_armed = 1'b0;
            shot_tally = '0;
            shot_results_due.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            // register writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_DROP_THRESHOLD: drop_thr = cfg_data;
                    REG_RISE_THRESHOLD: rise_thr = cfg_data;
                    default: ;
                endcase
            end
            // result transfer against the oldest one owed
            if (out_valid && !out_stall)
            begin
                if (shot_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result: count %0d shot %0b armed %0b full %0b",
                                 shots_counted, shot_now, armed, history_full);
                    end
                end
                else
                begin
                    due = shot_results_due.pop_front();
                    if (due.shots_counted !== shots_counted || due.shot_now !== shot_now ||
                        due.armed !== armed || due.history_full !== history_full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result mismatch: expected count %0d shot %0b armed %0b full %0b, got count %0d shot %0b armed %0b full %0b",
                                     due.shots_counted, due.shot_now, due.armed,
                                     due.history_full, shots_counted, shot_now, armed,
                                     history_full);
                        end
                    end
                end
            end
            // sample transfer
            if (in_valid && !in_stall)
            begin
                count_dip_shot(speed_sample, due);
                shot_results_due.push_back(due);
            end
            pending = shot_results_due.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// stimulus and verdict for the wheel speed dip shot counter
`timescale 1ns / 100ps

module tb
    import wsdsc_pkg::*;
();

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  speed_sample;
    logic                 out_valid;
    logic                 out_stall;
    logic [COUNT_W-1:0]   shots_counted;
    logic                 shot_now;
    logic                 armed;
    logic                 history_full;
    int                   mismatches;
    int                   pending;

    // idling switches and the thresholds the random samples are shaped around
    logic in_calm;
    logic out_calm;
    int   cur_drop;
    int   cur_rise;
    logic [SAMPLE_W-1:0] speed_plan [$];

    wheel_speed_dip_shot_counter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .speed_sample  (speed_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shots_counted (shots_counted),
        .shot_now      (shot_now),
        .armed         (armed),
        .history_full  (history_full)
    );

    dip_shot_monitor monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .speed_sample  (speed_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shots_counted (shots_counted),
        .shot_now      (shot_now),
        .armed         (armed),
        .history_full  (history_full),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #5000000;
        $display("FAIL wheel_speed_dip_shot_counter_top");
        $finish;
    end

    // result side: random hold-offs, one long one to back the block up
    initial
    begin : result_sink
        int n;
        int taken;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken == 700)
            begin
                n = 300;
            end
            else
            begin
                n = out_calm ? 0 : $urandom_range(0, 13);
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    // offer one sample after a random gap and hold it until the transfer
    task automatic send_speed(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        speed_sample <= value;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    // stop offering and wait until every owed result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // write both thresholds while the block is idle
    task automatic program_thresholds(input int drop, input int rise);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_DROP_THRESHOLD;
        cfg_data <= THR_W'(drop);
        @(negedge clk);
        cfg_index <= REG_RISE_THRESHOLD;
        cfg_data <= THR_W'(rise);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        cur_drop = drop;
        cur_rise = rise;
    endtask

    // magnitude with a random sign, sometimes the one value with no 16-bit magnitude
    function automatic logic [SAMPLE_W-1:0] with_sign(input int mag);
        if ($urandom_range(0, 1) == 0)
        begin
            return SAMPLE_W'(mag);
        end
        if (mag == 65535 && $urandom_range(0, 2) == 0)
        begin
            return SAMPLE_W'(-65536);
        end
        return SAMPLE_W'(-mag);
    endfunction

    // a speed step near a scaled threshold, mostly right on the edge
    function automatic int step_near(input int lim);
        int s;
        case ($urandom_range(0, 3))
            0: s = lim - 1;
            1: s = lim;
            2: s = lim + 1;
            default: s = lim + 1 + int'($urandom_range(0, 3000));
        endcase
        if (s < 0)
        begin
            s = 0;
        end
        if (s > 65535)
        begin
            s = 65535;
        end
        return s;
    endfunction

    // queue up one burst: a dip and recovery, raw noise, or a wandering level
    task automatic plan_burst();
        int kind;
        int hi;
        int lo;
        int peak;
        int dd;
        int dr;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            dd = step_near(cur_drop * WINDOW);
            dr = step_near(cur_rise * WINDOW);
            hi = $urandom_range(dd, 65535);
            lo = hi - dd;
            peak = lo + dr;
            if (peak > 65535)
            begin
                peak = 65535;
            end
            repeat ($urandom_range(3, 8)) speed_plan.push_back(with_sign(hi));
            repeat ($urandom_range(5, 8)) speed_plan.push_back(with_sign(lo));
            repeat ($urandom_range(1, 6)) speed_plan.push_back(with_sign(peak));
        end
        else if (kind < 8)
        begin
            repeat ($urandom_range(4, 16))
                speed_plan.push_back(SAMPLE_W'($urandom_range(0, 131071)));
        end
        else
        begin
            hi = $urandom_range(0, 65535);
            repeat ($urandom_range(3, 10))
            begin
                lo = hi + int'($urandom_range(0, 800)) - 400;
                if (lo < 0)
                begin
                    lo = 0;
                end
                if (lo > 65535)
                begin
                    lo = 65535;
                end
                speed_plan.push_back(with_sign(lo));
            end
        end
    endtask

    // one stretch of random samples, with the odd pause until drained
    task automatic run_phase(input int count);
        int sent;
        speed_plan.delete();
        for (sent = 0; sent < count; sent++)
        begin
            if (speed_plan.size() == 0)
            begin
                plan_burst();
            end
            if ($urandom_range(0, 199) == 0)
            begin
                wait_drained();
            end
            send_speed(speed_plan.pop_front());
        end
    endtask

    // reset, directed samples, then random phases over several threshold settings
    initial
    begin : stimulus
        int directed_speeds [0:17];
        int i;
        int ph;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_DROP_THRESHOLD;
        cfg_data = '0;
        in_valid = 1'b0;
        speed_sample = '0;
        out_stall = 1'b0;
        in_calm = 1'b0;
        out_calm = 1'b0;
        cur_drop = int'(DROP_THRESHOLD_RST);
        cur_rise = int'(RISE_THRESHOLD_RST);
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // thresholds at reset: fill, rise with nothing armed, drop on the edge then
        // past it, drop while armed, rise on the edge then past it, then the extremes
        directed_speeds = '{5000, -5000, 5000, 5000, 5000, 5000, 5251, 3500, 3499, 0,
                            5250, 5502, -65536, 0, 65535, -1, 1, -65535};
        for (i = 0; i < 18; i++)
        begin
            send_speed(SAMPLE_W'(directed_speeds[i]));
        end

        for (ph = 1; ph <= 8; ph++)
        begin
            wait_drained();
            in_calm = (ph % 4 == 2);
            out_calm = (ph % 3 == 0);
            case (ph)
                1: program_thresholds(300, 50);
                2: program_thresholds(0, 0);
                3: program_thresholds(65535, 65535);
                4: program_thresholds(0, 65535);
                5: program_thresholds(65535, 0);
                6: program_thresholds($urandom_range(0, 2000), $urandom_range(0, 2000));
                7: program_thresholds($urandom_range(0, 13107), $urandom_range(0, 13107));
                default: program_thresholds(1, 1);
            endcase
            run_phase(220);
        end

        // drain and allow for any stray result
        wait_drained();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("PASS wheel_speed_dip_shot_counter_top");
        end
        else
        begin
            $display("FAIL wheel_speed_dip_shot_counter_top");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/wsdsc_pkg.sv
sv/wheel_speed_dip_shot_counter_top.sv
bench/dip_shot_monitor.sv
bench/tb.sv
